>>> src/sle_pkg.sv
// Shared types and constants for the sorted list engine.
// Used by sle_ctrl, sle_datapath, sorted_list_engine and the testbench; no dependencies.
`default_nettype none

package sle_pkg;

    // Payload widths fixed by the interface
    localparam int VALUE_W = 32;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 3;
    localparam int CMD_W   = 2;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_DELETED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;
    localparam logic [STAT_W-1:0] ST_ENTRY    = 3'd5;

    // Table operation issued by the controller
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } dp_op_t;

    // Controller to datapath command
    typedef struct packed {
        dp_op_t            op;
        logic              load_out;
        logic [STAT_W-1:0] status;
        logic              last;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic found;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> src/sle_datapath.sv
// Datapath of the sorted list engine: compare-and-shift cells, count and
// the result payload register. Depends on sle_pkg.
`default_nettype none

module sle_datapath #(
    parameter int CAPACITY = 16,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic signed [sle_pkg::VALUE_W-1:0] in_value,
    input  wire sle_pkg::dp_cmd_t                   cmd,
    output sle_pkg::dp_stat_t                       stat,
    output logic [CW-1:0]                           count,
    output logic signed [sle_pkg::VALUE_W-1:0]      out_entry,
    output logic [sle_pkg::STAT_W-1:0]              out_status,
    output logic                                    out_last,
    output logic [sle_pkg::OCC_W-1:0]               out_occ
);

    logic signed [sle_pkg::VALUE_W-1:0] cell_reg  [CAPACITY];
    logic signed [sle_pkg::VALUE_W-1:0] cell_next [CAPACITY];
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic [CAPACITY-1:0]                ge;
    logic [CAPACITY-1:0]                eq;
    logic signed [sle_pkg::VALUE_W-1:0] entry_sel;

    logic signed [sle_pkg::VALUE_W-1:0] out_entry_reg;
    logic [sle_pkg::STAT_W-1:0]         out_status_reg;
    logic                               out_last_reg;
    logic [sle_pkg::OCC_W-1:0]          out_occ_reg;

    // Per-cell compare; slots past the count act as greater than any value
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ge[i] = (CW'(i) >= count_reg) || (cell_reg[i] >= in_value);
            eq[i] = (CW'(i) < count_reg) && (cell_reg[i] == in_value);
        end
    end

    assign stat.full  = (count_reg == CW'(CAPACITY));
    assign stat.empty = (count_reg == '0);
    assign stat.found = |eq;

    // Next cell contents per operation
    always_comb begin
        count_next = count_reg;
        for (int i = 0; i < CAPACITY; i++) begin
            cell_next[i] = cell_reg[i];
        end
        case (cmd.op)
            sle_pkg::OP_INSERT: begin
                // Open a slot at the first entry not below the value
                for (int i = 0; i < CAPACITY; i++) begin
                    if (ge[i]) begin
                        if (i > 0 && ge[(i > 0) ? i - 1 : 0]) begin
                            cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                        end else begin
                            cell_next[i] = in_value;
                        end
                    end
                end
                count_next = count_reg + CW'(1);
            end
            sle_pkg::OP_DELETE: begin
                // Sorted table: the first equal entry is the first one not below
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    if (ge[i]) begin
                        cell_next[i] = cell_reg[i + 1];
                    end
                end
                count_next = count_reg - CW'(1);
            end
            sle_pkg::OP_ROTATE: begin
                // Rotate the occupied part left by one; count rotations restore it
                for (int i = 0; i < CAPACITY; i++) begin
                    if (CW'(i) == count_reg - CW'(1)) begin
                        cell_next[i] = cell_reg[0];
                    end else if (CW'(i) < count_reg) begin
                        cell_next[i] = cell_reg[(i < CAPACITY - 1) ? i + 1 : i];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Select the entry field of the result
    always_comb begin
        case (cmd.status)
            sle_pkg::ST_ENTRY: entry_sel = cell_reg[0];
            sle_pkg::ST_EMPTY: entry_sel = '0;
            default:           entry_sel = in_value;
        endcase
    end

    // Hold the cells, no reset needed
    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    // Hold the count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Load the result payload; occupancy wraps to the field width
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_entry_reg  <= entry_sel;
            out_status_reg <= cmd.status;
            out_last_reg   <= cmd.last;
            out_occ_reg    <= sle_pkg::OCC_W'(count_next);
        end
    end

    assign count      = count_reg;
    assign out_entry  = out_entry_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;
    assign out_occ    = out_occ_reg;

endmodule

`default_nettype wire

>>> src/sle_ctrl.sv
// Controller of the sorted list engine: handshakes, readout sequencing and
// the result valid flag. Depends on sle_pkg.
`default_nettype none

module sle_ctrl #(
    parameter int CAPACITY = 16,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [sle_pkg::CMD_W-1:0]  in_command,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    input  wire sle_pkg::dp_stat_t          stat,
    input  wire logic [CW-1:0]              count,
    output sle_pkg::dp_cmd_t                cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] rd_cnt_reg;
    logic [CW-1:0] rd_cnt_next;
    logic          m_valid_reg;
    logic          m_valid_next;
    logic          out_free;
    logic          accept;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Decode commands and sequence the readout
    always_comb begin
        state_next   = state_reg;
        rd_cnt_next  = rd_cnt_reg;
        cmd.op       = sle_pkg::OP_NONE;
        cmd.load_out = 1'b0;
        cmd.status   = sle_pkg::ST_INSERTED;
        cmd.last     = 1'b1;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (in_command)
                        sle_pkg::CMD_INSERT: begin
                            cmd.load_out = 1'b1;
                            if (stat.full) begin
                                cmd.status = sle_pkg::ST_FULL;
                            end else begin
                                cmd.op     = sle_pkg::OP_INSERT;
                                cmd.status = sle_pkg::ST_INSERTED;
                            end
                        end
                        sle_pkg::CMD_DELETE: begin
                            cmd.load_out = 1'b1;
                            if (stat.empty) begin
                                cmd.status = sle_pkg::ST_EMPTY;
                            end else if (!stat.found) begin
                                cmd.status = sle_pkg::ST_NOTFOUND;
                            end else begin
                                cmd.op     = sle_pkg::OP_DELETE;
                                cmd.status = sle_pkg::ST_DELETED;
                            end
                        end
                        sle_pkg::CMD_READ: begin
                            cmd.load_out = 1'b1;
                            if (stat.empty) begin
                                cmd.status = sle_pkg::ST_EMPTY;
                            end else begin
                                cmd.op     = sle_pkg::OP_ROTATE;
                                cmd.status = sle_pkg::ST_ENTRY;
                                cmd.last   = (count == CW'(1));
                                if (count != CW'(1)) begin
                                    state_next  = S_READ;
                                    rd_cnt_next = CW'(1);
                                end
                            end
                        end
                        default: begin
                            // Drop the unused code without a result
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.op       = sle_pkg::OP_ROTATE;
                    cmd.status   = sle_pkg::ST_ENTRY;
                    cmd.last     = (rd_cnt_reg == count - CW'(1));
                    rd_cnt_next  = rd_cnt_reg + CW'(1);
                    if (rd_cnt_reg == count - CW'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, clear on transfer
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_cnt_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

>>> src/sorted_list_engine.sv
// Sorted list engine: keeps up to CAPACITY signed values in ascending order.
// Channels: s_tuser[1:0] command (insert, delete, read out), s_tdata value.
// Results: m_tuser status, m_tdata {occupancy, entry}, m_tlast marks the
// final result of each command.
// Insert and delete: one transfer per cycle while the output register is
// free or draining; each result appears in the output register in the
// cycle after its input transfer. Readout of N entries: N results, input
// held off until the last one is loaded; an empty table gives a single
// empty result. The compare-and-shift cells apply an insert or delete as
// its result is loaded; the single output register emits one readout entry
// per cycle from cell zero as the table rotates, while the receiver takes it.
// A new command is taken only while the output register is free or being
// drained, so a stalled receiver holds off input.
// Reset (aresetn low, synchronous) empties the table and clears the output
// valid; cell contents are not cleared and are never read unwritten.
// Depends on sle_pkg, sle_ctrl and sle_datapath.
`default_nettype none

module sorted_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] entry, [36:32] occupancy, rest zero
    output logic [2:0]       m_tuser,   // [2:0] status
    output logic             m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);

    sle_pkg::dp_cmd_t                   cmd;
    sle_pkg::dp_stat_t                  stat;
    logic [CW-1:0]                      count;
    logic signed [sle_pkg::VALUE_W-1:0] out_entry;
    logic [sle_pkg::OCC_W-1:0]          out_occ;

    sle_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_command (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .stat       (stat),
        .count      (count),
        .cmd        (cmd)
    );

    sle_datapath #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_value   (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .count      (count),
        .out_entry  (out_entry),
        .out_status (m_tuser),
        .out_last   (m_tlast),
        .out_occ    (out_occ)
    );

    // Pack the result data
    assign m_tdata = {3'b000, out_occ, out_entry};

`ifndef SYNTH
    // No input transfer while a result is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    // Count never exceeds the table size
    assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CW'(CAPACITY))
        else $error("count above capacity");

    // Every result other than a readout entry marks last
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != sle_pkg::ST_ENTRY) |-> m_tlast)
        else $error("single result without last");
`endif

endmodule

`default_nettype wire

>>> tb/sorted_list_checker.sv
// Checker for the sorted list engine: watches both stream channels, keeps a
// shadow copy of the sorted table and compares every result transfer.
// Depends on sle_pkg for command and status codes and payload widths.
module sorted_list_checker
    import sle_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // [31:0] entry, [36:32] occupancy, rest zero
    input  wire logic [2:0]  m_tuser,   // [2:0] status
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending,
    output int               result_count,
    output int               full_count,
    output int               miss_count,
    output int               longest_readout
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTS = 40;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] entry;
        logic               last;
        logic [OCC_W-1:0]   occupancy;
    } list_result_t;

    // Shadow of the table: ascending values, valid below stored_count
    logic signed [VALUE_W-1:0] shadow_table [CAPACITY];
    int unsigned               stored_count;
    list_result_t              awaited_results [$];

    int errors     = 0;
    int outstanding = 0;
    int results    = 0;
    int fulls      = 0;
    int misses     = 0;
    int run_len    = 0;
    int run_peak   = 0;

    assign fail_count      = errors;
    assign pending         = outstanding;
    assign result_count    = results;
    assign full_count      = fulls;
    assign miss_count      = misses;
    assign longest_readout = run_peak;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t ns sorted_list_checker: %s", $realtime, msg);
    endtask

    task automatic queue_result(input logic [STAT_W-1:0] status,
                                input logic [VALUE_W-1:0] entry,
                                input logic last);
        list_result_t r;
        r.status    = status;
        r.entry     = entry;
        r.last      = last;
        r.occupancy = stored_count[OCC_W-1:0];
        awaited_results.push_back(r);
    endtask

    // Update the shadow table for one accepted command and queue its results
    task automatic apply_list_command(input logic [CMD_W-1:0] cmd,
                                      input logic signed [VALUE_W-1:0] value);
        int unsigned pos;
        pos = 0;
        case (cmd)
            CMD_INSERT: begin
                if (stored_count >= CAPACITY) begin
                    queue_result(ST_FULL, value, 1'b1);
                end else begin
                    // place before the first entry that is greater or equal
                    while (pos < stored_count && shadow_table[pos] < value)
                        pos++;
                    for (int unsigned i = stored_count; i > pos; i--)
                        shadow_table[i] = shadow_table[i-1];
                    shadow_table[pos] = value;
                    stored_count++;
                    queue_result(ST_INSERTED, value, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (stored_count == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    while (pos < stored_count && shadow_table[pos] != value)
                        pos++;
                    if (pos >= stored_count) begin
                        queue_result(ST_NOTFOUND, value, 1'b1);
                    end else begin
                        for (int unsigned i = pos; i + 1 < stored_count; i++)
                            shadow_table[i] = shadow_table[i+1];
                        stored_count--;
                        queue_result(ST_DELETED, value, 1'b1);
                    end
                end
            end
            CMD_READ: begin
                if (stored_count == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < stored_count; i++)
                        queue_result(ST_ENTRY, shadow_table[i], i + 1 == stored_count);
                end
            end
            default: begin
                // unused command code: no state change, no result
            end
        endcase
    endtask

    // Compare one result transfer against the oldest expectation
    task automatic check_result();
        list_result_t want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result: status %0d entry %0d",
                                      m_tuser, $signed(m_tdata[31:0])));
        end else begin
            want = awaited_results.pop_front();
            if (m_tuser !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          m_tuser, want.status));
            if (m_tdata[31:0] !== want.entry)
                report_mismatch($sformatf("entry %0d, expected %0d",
                                          $signed(m_tdata[31:0]), $signed(want.entry)));
            if (m_tdata[36:32] !== want.occupancy)
                report_mismatch($sformatf("occupancy %0d, expected %0d",
                                          m_tdata[36:32], want.occupancy));
            if (m_tlast !== want.last)
                report_mismatch($sformatf("tlast %b, expected %b", m_tlast, want.last));
            if (m_tdata[39:37] !== 3'b000)
                report_mismatch($sformatf("tdata padding %b, expected zero",
                                          m_tdata[39:37]));
        end
        // tally what the run covered
        results++;
        if (m_tuser == ST_FULL)
            fulls++;
        if (m_tuser == ST_NOTFOUND)
            misses++;
        if (m_tuser == ST_ENTRY) begin
            run_len++;
            if (run_len > run_peak)
                run_peak = run_len;
        end
        if (m_tlast)
            run_len = 0;
    endtask

    // Sample both channels at the rising edge; predict before comparing
    always @(posedge aclk) begin
        if (!aresetn) begin
            awaited_results.delete();
            stored_count = 0;
            run_len      = 0;
        end else begin
            if (s_tvalid && s_tready)
                apply_list_command(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_result();
        end
        outstanding <= awaited_results.size();
    end

endmodule

>>> tb/tb_sorted_list_engine.sv
// Testbench top for the sorted list engine: drives commands, throttles the
// result channel and reports the verdict from sorted_list_checker.
// Depends on sle_pkg, sorted_list_engine and sorted_list_checker.
module tb_sorted_list_engine;
    import sle_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              CAPACITY     = 16;
    localparam int              RANDOM_ITEMS = 310;
    localparam int              IDLE_PCT     = 27;
    localparam int              CYCLE_LIMIT  = 200000;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam logic [31:0]     VAL_MIN      = 32'h8000_0000;
    localparam logic [31:0]     VAL_MAX      = 32'h7FFF_FFFF;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic [1:0]  s_tuser;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // [31:0] entry, [36:32] occupancy, rest zero
    logic [2:0]  m_tuser;   // [2:0] status
    logic        m_tlast;

    int fail_count, pending, result_count, full_count, miss_count, longest_readout;
    int cycle_count = 0;
    int n_insert    = 0;
    int n_delete    = 0;
    int n_read      = 0;
    int n_ignored   = 0;
    logic steady_flow = 1'b0;

    sorted_list_engine #(.CAPACITY(CAPACITY)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sorted_list_checker #(.CAPACITY(CAPACITY)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending         (pending),
        .result_count    (result_count),
        .full_count      (full_count),
        .miss_count      (miss_count),
        .longest_readout (longest_readout)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: end the run with a failure once the cycle limit is reached
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, pending);
            $display("tb_sorted_list_engine: FAIL");
            $finish;
        end
    end

    // Throttle the result channel, except during the steady stretch
    always @(negedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Present one command and hold it until the transfer; call at a falling edge
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [31:0] value);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 2'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        case (cmd)
            CMD_INSERT: n_insert++;
            CMD_DELETE: n_delete++;
            CMD_READ:   n_read++;
            default:    n_ignored++;
        endcase
    endtask

    // Drop valid and hold off until every awaited result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0)
            @(negedge aclk);
    endtask

    initial begin
        int               mode;
        int               phase_len;
        int               phase;
        int               random_done;
        int               ins_pct;
        int               del_pct;
        int               r;
        logic [CMD_W-1:0] cmd;
        logic [31:0]      value;
        logic [31:0]      value_pool [8];

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty table cases, extremes, duplicates, misses, unused code
        send_command(CMD_READ,   32'd0);
        send_command(CMD_DELETE, 32'd5);
        send_command(CMD_UNUSED, VAL_MAX);
        send_command(CMD_INSERT, VAL_MAX);
        send_command(CMD_INSERT, VAL_MIN);
        send_command(CMD_INSERT, 32'd0);
        send_command(CMD_INSERT, 32'd0);
        send_command(CMD_INSERT, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 32'd1);
        send_command(CMD_READ,   32'hFFFF_FFFF);
        send_command(CMD_DELETE, 32'd7);
        send_command(CMD_DELETE, 32'd0);
        send_command(CMD_DELETE, VAL_MIN);
        send_command(CMD_DELETE, VAL_MAX);
        send_command(CMD_READ,   32'd0);
        send_command(CMD_UNUSED, 32'd0);
        send_command(CMD_DELETE, 32'hFFFF_FFFF);
        send_command(CMD_DELETE, 32'd1);
        send_command(CMD_DELETE, 32'd0);
        send_command(CMD_DELETE, 32'd0);
        send_command(CMD_READ,   32'd0);
        drain_results();

        // Random phases: fill, drain or mixed, with values drawn mostly from a small
        // pool or a narrow range so that duplicates and successful deletes are common
        foreach (value_pool[i])
            value_pool[i] = $urandom;
        phase       = 0;
        random_done = 0;
        while (random_done < RANDOM_ITEMS) begin
            mode        = (phase == 0) ? 0 : $urandom_range(0, 2);
            phase_len   = (phase == 0) ? 40 : $urandom_range(15, 45);
            steady_flow = (phase >= 4 && phase <= 6);
            value_pool[$urandom_range(0, 7)] = $urandom;
            case (mode)
                0:       begin ins_pct = 75; del_pct = 10; end
                1:       begin ins_pct = 10; del_pct = 75; end
                default: begin ins_pct = 40; del_pct = 40; end
            endcase
            for (int k = 0; k < phase_len && random_done < RANDOM_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    cmd = CMD_INSERT;
                else if (r < ins_pct + del_pct)
                    cmd = CMD_DELETE;
                else if (r < 96)
                    cmd = CMD_READ;
                else
                    cmd = CMD_UNUSED;
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    value = value_pool[$urandom_range(0, 7)];
                end else if (r < 70) begin
                    value = int'($urandom_range(0, 6)) - 3;
                end else if (r < 78) begin
                    case ($urandom_range(0, 3))
                        0:       value = VAL_MIN;
                        1:       value = VAL_MAX;
                        2:       value = '0;
                        default: value = '1;
                    endcase
                end else begin
                    value = $urandom;
                end
                send_command(cmd, value);
                if (cmd != CMD_UNUSED)
                    random_done++;
            end
            // let the pipeline run dry now and then
            if (phase % 4 == 3)
                drain_results();
            phase++;
        end
        steady_flow = 1'b0;

        // Wait out the last results, then allow for any stray transfer
        drain_results();
        repeat (CAPACITY + 8) @(negedge aclk);

        $display("covered %0d inserts, %0d deletes, %0d readouts, %0d unused codes",
                 n_insert, n_delete, n_read, n_ignored);
        $display("checked %0d results: %0d full drops, %0d delete misses, longest readout %0d",
                 result_count, full_count, miss_count, longest_readout);
        if (fail_count == 0)
            $display("tb_sorted_list_engine: PASS");
        else
            $display("tb_sorted_list_engine: FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/sle_pkg.sv
src/sle_datapath.sv
src/sle_ctrl.sv
src/sorted_list_engine.sv
tb/sorted_list_checker.sv
tb/tb_sorted_list_engine.sv
